// ===== sv/bit_matrix_transpose_64x64_defines.svh =====
// assertion macros for the bit matrix transpose checker
// no dependencies; included by the checker file only
`ifndef BIT_MATRIX_TRANSPOSE_64X64_DEFINES_SVH
`define BIT_MATRIX_TRANSPOSE_64X64_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bmt_pkg.sv =====
// shared types and constants for the bit matrix transpose
// no dependencies
package bmt_pkg;

	localparam int unsigned ROW_W = 64;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic emit;
		logic last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ===== sv/bmt_if.sv =====
// valid/ready channel interfaces for row words in and transposed words out
// depends on bmt_pkg
interface bmt_in_if;
	logic                      valid;
	logic                      ready;
	logic [bmt_pkg::ROW_W-1:0] row_bits;

	modport source (output valid, output row_bits, input ready);
	modport sink (input valid, input row_bits, output ready);
endinterface

interface bmt_out_if;
	logic                      valid;
	logic                      ready;
	logic [bmt_pkg::ROW_W-1:0] col_bits;
	logic                      last_row;

	modport source (output valid, output col_bits, output last_row, input ready);
	modport sink (input valid, input col_bits, input last_row, output ready);
endinterface

// ===== sv/bmt_ctrl.sv =====
// controller: load/emit state machine and row counter
// depends on bmt_pkg
module bmt_ctrl #(
	parameter int unsigned DIM = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bmt_pkg::sts_t sts,
	output bmt_pkg::cmd_t cmd
);

	localparam int unsigned CNT_W = $clog2(DIM);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIM - 1);

	bmt_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmt_pkg::ST_LOAD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.last = (cnt_q == CNT_LAST);
		case (state_q)
			bmt_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			bmt_pkg::ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				state_d = bmt_pkg::ST_LOAD;
			end
		endcase
		if (cmd.load || cmd.emit) begin
			if (cmd.last) begin
				cnt_d   = '0;
				state_d = cmd.load ? bmt_pkg::ST_EMIT : bmt_pkg::ST_LOAD;
			end else begin
				cnt_d = cnt_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/bmt_dp.sv =====
// datapath: row shift line, column tap and output word register
// depends on bmt_pkg
module bmt_dp #(
	parameter int unsigned DIM = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bmt_pkg::cmd_t             cmd,
	output bmt_pkg::sts_t             sts,
	input  logic [bmt_pkg::ROW_W-1:0] row_bits,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bmt_pkg::ROW_W-1:0] col_bits,
	output logic                      last_row
);

	logic [DIM-1:0] tap_q [DIM];
	logic [DIM-1:0] col_d;
	logic [DIM-1:0] col_q;
	logic           last_q;
	logic           out_valid_q;

	// loading shifts rows toward tap 0; emitting shifts every row right by one
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < DIM - 1; i++) begin
				tap_q[i] <= tap_q[i+1];
			end
			tap_q[DIM-1] <= row_bits[DIM-1:0];
		end else if (cmd.emit) begin
			for (int i = 0; i < DIM; i++) begin
				tap_q[i] <= tap_q[i] >> 1;
			end
		end
	end

	// bit 0 of every row forms the current transposed word
	always_comb begin
		for (int c = 0; c < DIM; c++) begin
			col_d[c] = tap_q[c][0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			col_q  <= col_d;
			last_q <= cmd.last;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign col_bits     = bmt_pkg::ROW_W'(col_q);
	assign last_row     = last_q;

endmodule

// ===== sv/bit_matrix_transpose_64x64.sv =====
// channel  | dir | payload                 | handshake
// rows     | in  | row_bits[63:0]          | valid/ready
// cols     | out | col_bits[63:0], last_row | valid/ready
//
// a matrix is loaded one word per cycle while rows.valid is high, and is then
// emitted; the next matrix is not loaded until the emit ends, as the single
// row shift line both loads and unloads.
// reset clears the state machine, row counter and output valid; no clearing pass.
// an output stall holds the emit; loading of the next matrix starts while the
// final word still waits in the output register.
// top level: bit matrix transpose; depends on bmt_pkg, bmt_if, bmt_ctrl, bmt_dp
module bit_matrix_transpose_64x64 #(
	parameter int unsigned DIM = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	bmt_in_if.sink   rows,
	bmt_out_if.source cols
);

	bmt_pkg::cmd_t cmd;
	bmt_pkg::sts_t sts;

	bmt_ctrl #(
		.DIM(DIM)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(rows.valid),
		.in_ready(rows.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bmt_dp #(
		.DIM(DIM)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.row_bits (rows.row_bits),
		.out_valid(cols.valid),
		.out_ready(cols.ready),
		.col_bits (cols.col_bits),
		.last_row (cols.last_row)
	);

endmodule

// ===== sv/bmt_chk.sv =====
// port-level checker for the bit matrix transpose, bound to the top level
// depends on bmt_pkg and bit_matrix_transpose_64x64_defines.svh
`include "bit_matrix_transpose_64x64_defines.svh"

module bmt_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [bmt_pkg::ROW_W-1:0] col_bits,
	input logic                      last_row
);

	// no input is taken while a matrix is still being emitted
	`BMT_ASSERT_IMP(a_no_load_mid_emit, clk, arst_n, out_valid && !last_row, !in_ready, "input ready during emit")

	// a taken word that is not the last is followed at once by the next word
	`BMT_ASSERT_NXT(a_emit_back_to_back, clk, arst_n, out_valid && out_ready && !last_row, out_valid, "gap inside emitted matrix")

	// loading only ends on a taken word
	`BMT_ASSERT_NXT(a_ready_holds, clk, arst_n, in_ready && !in_valid, in_ready, "input ready dropped")

	// stalled output word holds
	`BMT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(col_bits) && $stable(last_row), "stalled output word changed")

endmodule

bind bit_matrix_transpose_64x64 bmt_chk u_bmt_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (rows.valid),
	.in_ready (rows.ready),
	.out_valid(cols.valid),
	.out_ready(cols.ready),
	.col_bits (cols.col_bits),
	.last_row (cols.last_row)
);
